// ----- hw/rtl/box_downsample_2x2_top_assert.svh -----
// assertion macros used by the rtl files (included by bds_back)
`ifndef BOX_DOWNSAMPLE_2X2_TOP_ASSERT_SVH
`define BOX_DOWNSAMPLE_2X2_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bds_pkg.sv -----
`default_nettype none

package bds_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CMD_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    localparam int CFG_W        = 12;
    localparam int CFG_MAX      = (1 << CFG_W) - 1;
    localparam int ROW_W        = 11;
    localparam int HEIGHT_MAX   = 2048;
    localparam int SIZE_MIN     = 2;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int PIX_W        = 8;
    localparam int PAIR_W       = PIX_W + 1;
    localparam int QUAD_W       = PIX_W + 2;

    typedef enum logic {
        OP_STORE,
        OP_EMIT
    } t_op;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // work handed from front to back (line index travels beside it)
    typedef struct packed {
        t_op               op;
        logic [PAIR_W-1:0] pair;
        logic              row_end;
        logic              frame_end;
    } t_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] average;
        logic             row_end;
        logic             frame_end;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/bds_fifo.sv -----
`default_nettype none

module bds_fifo
    import bds_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic [WIDTH-1:0]        o_data,
    output logic                    o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bds_front.sv -----
`default_nettype none

module bds_front
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int LINE_DEPTH = MAX_WIDTH / 2,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_push,
    input  wire logic             i_full,
    input  wire logic [PIX_W-1:0] i_pixel_value,
    input  wire logic             i_frame_start,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd,
    output logic [AW-1:0]         o_cmd_idx
);

    localparam int WMAX  = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int CW    = $clog2(WMAX);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = ((WB > CFG_W) ? WB : CFG_W) + 1;

    logic [CFG_W-1:0]  r_width, r_height;
    logic [CW-1:0]     r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [PIX_W-1:0]  r_left;

    logic [CMPW-1:0]   width_x, w_eff, even_w, col_x, col_next;
    logic [CFG_W-1:0]  h_eff, even_h, row_x, row_next;
    logic [CW-1:0]     col;
    logic [ROW_W-1:0]  row;
    logic              accept, in_area, odd_col;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(WIDTH_RESET);
            r_height <= CFG_W'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default:          r_width  <= r_width;
            endcase
        end
    end

    // clamp geometry
    always_comb begin
        width_x = CMPW'(r_width);
        if (width_x < CMPW'(SIZE_MIN)) begin
            w_eff = CMPW'(SIZE_MIN);
        end else if (width_x > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = width_x;
        end
        if (r_height < CFG_W'(SIZE_MIN)) begin
            h_eff = CFG_W'(SIZE_MIN);
        end else if (r_height > CFG_W'(HEIGHT_MAX)) begin
            h_eff = CFG_W'(HEIGHT_MAX);
        end else begin
            h_eff = r_height;
        end
        even_w = {w_eff[CMPW-1:1], 1'b0};
        even_h = {h_eff[CFG_W-1:1], 1'b0};
    end

    // position of this pixel and classification
    assign accept   = i_push && !i_full;
    assign col      = i_frame_start ? '0 : r_col;
    assign row      = i_frame_start ? '0 : r_row;
    assign col_x    = CMPW'(col);
    assign row_x    = CFG_W'(row);
    assign col_next = col_x + 1'b1;
    assign row_next = row_x + 1'b1;
    assign in_area  = (col_x < even_w) && (row_x < even_h);
    assign odd_col  = col[0];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_next >= w_eff) begin
                n_col = '0;
                n_row = (row_next >= h_eff) ? '0 : ROW_W'(row_next);
            end else begin
                n_col = CW'(col_next);
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept && in_area && !odd_col) begin
                r_left <= i_pixel_value;
            end
        end
    end

    // one word per completed pair
    always_comb begin
        o_cmd_push      = accept && in_area && odd_col;
        o_cmd.op        = row[0] ? OP_EMIT : OP_STORE;
        o_cmd.pair      = PAIR_W'(r_left) + PAIR_W'(i_pixel_value);
        o_cmd.row_end   = (col_x == even_w - 1'b1);
        o_cmd.frame_end = (col_x == even_w - 1'b1) && (row_x == even_h - 1'b1);
        o_cmd_idx       = AW'(col >> 1);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bds_back.sv -----
`default_nettype none

`include "box_downsample_2x2_top_assert.svh"

module bds_back
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF,
    localparam int LINE_DEPTH = MAX_WIDTH / 2,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [AW-1:0] i_cmd_idx,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output t_result            o_result
);

    localparam int CNTW = $clog2(OUT_DEPTH + 1);

    logic [PAIR_W-1:0] r_line [LINE_DEPTH];
    logic [PAIR_W-1:0] r_rd_sum;
    logic [PAIR_W-1:0] r_s1_pair;
    logic              r_s1_rend, r_s1_fend;
    logic              r_s1_valid;

    logic [CNTW-1:0]   out_count;
    logic              out_full;
    logic              credit, store_we, emit_re;
    logic [QUAD_W-1:0] quad_sum;
    t_result           result;
    logic [$bits(t_result)-1:0] out_data;

    // an emit needs a free output slot counting the one in flight
    assign credit    = ((CNTW+1)'(out_count) + (CNTW+1)'(r_s1_valid)) < (CNTW+1)'(OUT_DEPTH);
    assign o_cmd_pop = !i_cmd_empty && ((i_cmd.op == OP_STORE) || credit);
    assign store_we  = o_cmd_pop && (i_cmd.op == OP_STORE);
    assign emit_re   = o_cmd_pop && (i_cmd.op == OP_EMIT);

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_line[i_cmd_idx] <= i_cmd.pair;
        end
        if (emit_re) begin
            r_rd_sum <= r_line[i_cmd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_re) begin
            r_s1_pair <= i_cmd.pair;
            r_s1_rend <= i_cmd.row_end;
            r_s1_fend <= i_cmd.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= emit_re;
        end
    end

    always_comb begin
        quad_sum         = QUAD_W'(r_rd_sum) + QUAD_W'(r_s1_pair);
        result.average   = quad_sum[QUAD_W-1:2];
        result.row_end   = r_s1_rend;
        result.frame_end = r_s1_fend;
    end

    bds_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_data),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign o_result = t_result'(out_data);

    `BDS_ASSERT_NOW(a_no_push_on_full, i_clk, i_rst_n, r_s1_valid, !out_full,
        "result written into a full output queue")
    `BDS_ASSERT_NEXT(a_emit_reaches_s1, i_clk, i_rst_n, emit_re, r_s1_valid,
        "issued emit did not reach the add stage")
    `BDS_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, o_cmd_pop, !i_cmd_empty,
        "command popped from an empty queue")

endmodule

`default_nettype wire

// ----- hw/rtl/box_downsample_2x2_top.sv -----
// a result word reaches the result ports after the odd-row, odd-column pixel completing its
//   2x2 block passes the command queue, the line read into the add stage, and the result queue
// throughput: 1 pixel per cycle while full is low; the line buffer takes one access per pixel pair
// full rises only when the command queue backs up behind a stalled result queue
// reset (synchronous, active low) empties both queues, zeros position and left pixel,
//   and loads width 640 and height 480; the line buffer is not cleared
`default_nettype none

module box_downsample_2x2_top
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration write port
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    // pixel input queue side
    input  wire logic             push,
    output logic                  full,
    input  wire logic [PIX_W-1:0] i_pixel_value,
    input  wire logic             i_frame_start,
    // result queue side
    output logic                  empty,
    input  wire logic             pop,
    output logic [PIX_W-1:0]      o_average,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int QW = $bits(t_cmd) + AW;

    // front to queue
    logic          front_push;
    t_cmd          front_cmd;
    logic [AW-1:0] front_idx;

    // queue to back
    logic [QW-1:0] q_data;
    logic          q_empty, q_pop;
    t_cmd          back_cmd;
    logic [AW-1:0] back_idx;
    t_result       result;

    // front: geometry, position counters, left pixel, pair add
    bds_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_pixel_value (i_pixel_value),
        .i_frame_start (i_frame_start),
        .o_cmd_push    (front_push),
        .o_cmd         (front_cmd),
        .o_cmd_idx     (front_idx)
    );

    // short command queue lets front and back stall on their own
    bds_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_idx, front_cmd}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_count ()
    );

    assign back_cmd = t_cmd'(q_data[$bits(t_cmd)-1:0]);
    assign back_idx = q_data[QW-1:$bits(t_cmd)];

    // back: line buffer store or read, block average, result queue
    bds_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_idx   (back_idx),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_average   = result.average;
    assign o_row_end   = result.row_end;
    assign o_frame_end = result.frame_end;

endmodule

`default_nettype wire
